### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; they compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

### hw/rtl/iul_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval union length package
// Sizes, codes and controller/datapath interface types of the block.
// ----------------------------------------------------------------------------
package iul_pkg;

    localparam int MAX_INTERVALS = 16;
    localparam int NUM_STAGES    = 3;

    localparam int TABLE_DEPTH = MAX_INTERVALS * NUM_STAGES;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int IDX_W       = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int CNT_W       = $clog2(MAX_INTERVALS + 1);
    localparam int SEL_W       = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;

    localparam int STAGE_W = 2;
    localparam int TIME_W  = 64;

    localparam int IN_TDATA_W  = 2 * TIME_W;
    localparam int IN_TUSER_W  = 1 + STAGE_W;
    localparam int OUT_TDATA_W = 72;
    localparam int OUT_PAD_W   = OUT_TDATA_W - TIME_W - 1;
    localparam int OUT_TUSER_W = STAGE_W;

    typedef enum logic [0:0] {
        CMD_ADD    = 1'b0,
        CMD_REPORT = 1'b1
    } t_command;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_SCAN,
        S_ADD_STORE,
        S_REP_SCAN,
        S_REP_EMIT
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic load;
        logic add_scan;
        logic add_store;
        logic rep_scan;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic is_report;
        logic add_ok;
        logic scan_done;
        logic out_free;
        logic last_stage;
    } t_dp_status;

endpackage

### hw/rtl/iul_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval union length controller
// Sequences add scans, table stores and the per-stage report passes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module iul_ctrl
    import iul_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_status.is_report) begin
                        n_state = S_REP_SCAN;
                    end else if (i_status.add_ok) begin
                        n_state = S_ADD_SCAN;
                    end
                end
            end
            S_ADD_SCAN: begin
                o_cmd.add_scan = 1'b1;
                if (i_status.scan_done) begin
                    n_state = S_ADD_STORE;
                end
            end
            S_ADD_STORE: begin
                o_cmd.add_store = 1'b1;
                n_state         = S_IDLE;
            end
            S_REP_SCAN: begin
                o_cmd.rep_scan = 1'b1;
                if (i_status.scan_done) begin
                    n_state = S_REP_EMIT;
                end
            end
            S_REP_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_status.last_stage ? S_IDLE : S_REP_SCAN;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // A report always starts with a scan of the first stage.
    `ASSERT_NEXT(a_report_starts_scan, i_clk, i_rst_n,
        (r_state == S_IDLE) && i_in_valid && i_status.is_report,
        r_state == S_REP_SCAN, "report transfer did not start a scan")

endmodule

### hw/rtl/iul_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval union length datapath
// Interval table memory, merge and compaction logic, length summing, output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module iul_datapath
    import iul_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    output t_dp_status             o_status,
    input  logic [IN_TDATA_W-1:0]  i_in_tdata,
    input  logic [IN_TUSER_W-1:0]  i_in_tuser,
    input  logic                   i_out_tready,
    output logic                   o_out_tvalid,
    output logic [OUT_TDATA_W-1:0] o_out_tdata,
    output logic [OUT_TUSER_W-1:0] o_out_tuser,
    output logic                   o_out_tlast
);

    localparam logic [STAGE_W:0] STAGE_LIMIT = (STAGE_W + 1)'(NUM_STAGES);
    localparam logic [CNT_W-1:0] CNT_FULL    = CNT_W'(MAX_INTERVALS);
    localparam logic [SEL_W-1:0] SEL_LAST    = SEL_W'(NUM_STAGES - 1);

    // Table memory, each word holds {begin, finish}.
    logic [2*TIME_W-1:0] r_mem [TABLE_DEPTH];
    logic [2*TIME_W-1:0] r_rd_data;

    logic [SEL_W-1:0]  r_stage;
    logic [TIME_W-1:0] r_lo;
    logic [TIME_W-1:0] r_hi;
    logic [CNT_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_w;
    logic              r_absorbed;
    logic              r_rd_valid;
    logic [TIME_W-1:0] r_len;
    logic              r_len_valid;
    logic [TIME_W-1:0] r_sum;
    logic [CNT_W-1:0]  r_count [NUM_STAGES];
    logic              r_dropped;

    logic              r_out_valid;
    logic [STAGE_W-1:0] r_out_stage;
    logic [TIME_W-1:0] r_out_sum;
    logic              r_out_ovf;
    logic              r_out_last;

    t_command          in_command;
    logic [STAGE_W-1:0] in_stage;
    logic [TIME_W-1:0] in_start;
    logic [TIME_W-1:0] in_end;

    logic [CNT_W-1:0]  cur_count;
    logic [ADDR_W-1:0] base;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [TIME_W-1:0] rd_begin;
    logic [TIME_W-1:0] rd_finish;
    logic              hit;
    logic              scan_wr;
    logic              drop;
    logic              store_wr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [2*TIME_W-1:0] wr_data;
    logic [TIME_W:0]   sum_ext;
    logic              out_free;
    logic              last_stage;

    assign in_command = t_command'(i_in_tuser[0]);
    assign in_stage   = i_in_tuser[STAGE_W:1];
    assign in_start   = i_in_tdata[TIME_W-1:0];
    assign in_end     = i_in_tdata[2*TIME_W-1:TIME_W];

    assign cur_count = r_count[r_stage];
    assign base      = ADDR_W'(r_stage) * ADDR_W'(MAX_INTERVALS);
    assign rd_en     = (i_cmd.add_scan || i_cmd.rep_scan) && (r_idx < cur_count);
    assign rd_addr   = base + ADDR_W'(r_idx[IDX_W-1:0]);
    assign rd_begin  = r_rd_data[2*TIME_W-1:TIME_W];
    assign rd_finish = r_rd_data[TIME_W-1:0];

    // Overlapping or touching intervals are absorbed into the running one.
    assign hit      = (rd_finish >= r_lo) && (rd_begin <= r_hi);
    assign scan_wr  = i_cmd.add_scan && r_rd_valid && !hit;
    assign drop     = !r_absorbed && (r_w == CNT_FULL);
    assign store_wr = i_cmd.add_store && !drop;
    assign wr_en    = scan_wr || store_wr;
    assign wr_addr  = base + ADDR_W'(r_w[IDX_W-1:0]);
    assign wr_data  = scan_wr ? r_rd_data : {r_lo, r_hi};

    assign sum_ext    = {1'b0, r_sum} + {1'b0, r_len};
    assign out_free   = !r_out_valid || i_out_tready;
    assign last_stage = (r_stage == SEL_LAST);

    always_comb begin
        o_status.is_report  = (in_command == CMD_REPORT);
        o_status.add_ok     = ({1'b0, in_stage} < STAGE_LIMIT) && (in_end >= in_start);
        o_status.scan_done  = (r_idx == cur_count) && !r_rd_valid && !r_len_valid;
        o_status.out_free   = out_free;
        o_status.last_stage = last_stage;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid  <= 1'b0;
            r_len_valid <= 1'b0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
            for (int s = 0; s < NUM_STAGES; s++) begin
                r_count[s] <= '0;
            end
        end else begin
            r_rd_valid  <= rd_en;
            r_len_valid <= i_cmd.rep_scan && r_rd_valid;
            if (i_cmd.add_store) begin
                if (drop) begin
                    r_dropped <= 1'b1;
                end else begin
                    r_count[r_stage] <= r_w + CNT_W'(1);
                end
            end
            if (i_cmd.emit && last_stage) begin
                r_dropped <= 1'b0;
                for (int s = 0; s < NUM_STAGES; s++) begin
                    r_count[s] <= '0;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_stage    <= (in_command == CMD_REPORT) ? '0 : SEL_W'(in_stage);
            r_lo       <= in_start;
            r_hi       <= in_end;
            r_idx      <= '0;
            r_w        <= '0;
            r_absorbed <= 1'b0;
            r_sum      <= '0;
        end
        if (rd_en) begin
            r_idx <= r_idx + CNT_W'(1);
        end
        if (i_cmd.add_scan && r_rd_valid) begin
            if (hit) begin
                r_absorbed <= 1'b1;
                if (rd_begin < r_lo) begin
                    r_lo <= rd_begin;
                end
                if (rd_finish > r_hi) begin
                    r_hi <= rd_finish;
                end
            end else begin
                r_w <= r_w + CNT_W'(1);
            end
        end
        if (i_cmd.rep_scan && r_rd_valid) begin
            r_len <= rd_finish - rd_begin;
        end
        if (i_cmd.rep_scan && r_len_valid) begin
            r_sum <= sum_ext[TIME_W] ? '1 : sum_ext[TIME_W-1:0];
        end
        if (i_cmd.emit) begin
            r_out_stage <= STAGE_W'(r_stage);
            r_out_sum   <= r_sum;
            r_out_ovf   <= r_dropped;
            r_out_last  <= last_stage;
            if (!last_stage) begin
                r_stage <= r_stage + SEL_W'(1);
                r_idx   <= '0;
                r_sum   <= '0;
            end
        end
    end

    assign o_out_tvalid = r_out_valid;
    assign o_out_tdata  = {OUT_PAD_W'(0), r_out_ovf, r_out_sum};
    assign o_out_tuser  = r_out_stage;
    assign o_out_tlast  = r_out_last;

    // Compaction must never overwrite an entry that has not been read yet.
    `ASSERT_IMPLY(a_wr_behind_rd, i_clk, i_rst_n, scan_wr, r_w < r_idx,
        "compaction write overtook the read pointer")

    // A stored interval always lands inside its stage's table.
    `ASSERT_IMPLY(a_store_in_range, i_clk, i_rst_n, store_wr, r_w < CNT_FULL,
        "interval stored beyond the table size")

    // A result is only loaded when the output register can take it.
    `ASSERT_IMPLY(a_emit_when_free, i_clk, i_rst_n, i_cmd.emit,
        !r_out_valid || i_out_tready, "result loaded over a pending transfer")

endmodule

### hw/rtl/interval_union_length_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval union length unit
// Per-stage union of time intervals, reported as saturating summed lengths.
// ----------------------------------------------------------------------------
// Input stream: tuser = {stage, command}; tdata = {end_time, start_time}.
// An add transfer merges [start_time, end_time] into its stage's table,
// absorbing every stored interval that overlaps or touches it. An add scans
// the entries already held by that stage, then stores the merged interval
// unless the table is full; the scan reads one table entry per cycle. Adds
// with an unknown stage or end before start are taken and change no table.
// A report transfer produces three output transfers, one per stage, in
// stage order; tlast marks the third. Each stage's entries are scanned and
// their lengths summed before its result is loaded into the output register.
// After the third result all tables and the overflow flag are cleared.
// The input is ready whenever no item is in work, even while a result waits
// in the output register. If the receiver stalls, a report holds before
// loading its next result until the pending one is taken.
// Reset empties all tables and clears the overflow flag at once.
// ----------------------------------------------------------------------------
module interval_union_length_unit
    import iul_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // start_time, end_time
    input  logic [IN_TUSER_W-1:0]  i_s_axis_tuser,   // command, stage
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,   // total_time, overflow, zero pad
    output logic [OUT_TUSER_W-1:0] o_m_axis_tuser,   // out_stage
    output logic                   o_m_axis_tlast
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    iul_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    iul_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_status     (dp_status),
        .i_in_tdata   (i_s_axis_tdata),
        .i_in_tuser   (i_s_axis_tuser),
        .i_out_tready (i_m_axis_tready),
        .o_out_tvalid (o_m_axis_tvalid),
        .o_out_tdata  (o_m_axis_tdata),
        .o_out_tuser  (o_m_axis_tuser),
        .o_out_tlast  (o_m_axis_tlast)
    );

    assign o_s_axis_tready = dp_cmd.in_ready;

endmodule

### tb/tb_interval_union_length_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval union length unit testbench
// Streams interval adds and reports into the unit and checks every per-stage
// sum against a scoreboard that keeps its own copy of the interval tables.
// Both stream sides idle at random, and the result side holds off once long
// enough to back the unit up.
// ----------------------------------------------------------------------------
module tb_interval_union_length_unit;
    import iul_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned RANDOM_ITEMS = 360;
    localparam int unsigned QUIET_ITEMS  = 60;
    localparam logic [TIME_W-1:0] TIME_MAX   = '1;
    localparam logic [TIME_W-1:0] SPAN_ROOM  = 64'd16384;

    // Mirror of the per-stage interval tables and the queue of sums owed.
    class span_scoreboard;
        typedef struct {
            logic [STAGE_W-1:0] stage;
            logic [TIME_W-1:0]  total;
            logic               ovf;
            logic               last;
        } t_stage_sum;

        logic [TIME_W-1:0] span_lo [NUM_STAGES][MAX_INTERVALS];
        logic [TIME_W-1:0] span_hi [NUM_STAGES][MAX_INTERVALS];
        int unsigned       span_used [NUM_STAGES];
        bit                dropped;
        t_stage_sum        sums_due[$];
        int unsigned       mismatches, adds, absorbs, drops, ignored, reports, results;

        task log_mismatch(input string msg);
            mismatches++;
            if (mismatches <= 20) begin
                $display("MISMATCH at %0t ns: %s", $time, msg);
            end
        endtask

        function void merge_span(input int unsigned s, input logic [TIME_W-1:0] lo,
                                 input logic [TIME_W-1:0] hi);
            int unsigned       kept;
            bit                hit;
            logic [TIME_W-1:0] b, f;
            kept = 0;
            hit  = 1'b0;
            adds++;
            // The growing interval is compared against each later entry, so a
            // chain of entries bridged by the merge is absorbed in one pass.
            for (int i = 0; i < span_used[s]; i++) begin
                b = span_lo[s][i];
                f = span_hi[s][i];
                if (f >= lo && b <= hi) begin
                    if (b < lo) lo = b;
                    if (f > hi) hi = f;
                    hit = 1'b1;
                end else begin
                    span_lo[s][kept] = b;
                    span_hi[s][kept] = f;
                    kept++;
                end
            end
            if (hit) absorbs++;
            if (!hit && kept >= MAX_INTERVALS) begin
                dropped = 1'b1;
                drops++;
            end else begin
                span_lo[s][kept] = lo;
                span_hi[s][kept] = hi;
                span_used[s]     = kept + 1;
            end
        endfunction

        function void note_input(input t_command cmd, input logic [STAGE_W-1:0] stage,
                                 input logic [TIME_W-1:0] lo, input logic [TIME_W-1:0] hi);
            t_stage_sum        item;
            logic [TIME_W-1:0] sum, len;
            if (cmd == CMD_ADD) begin
                if (stage < NUM_STAGES && hi >= lo) begin
                    merge_span(stage, lo, hi);
                end else begin
                    ignored++;
                end
            end else begin
                reports++;
                for (int s = 0; s < NUM_STAGES; s++) begin
                    sum = '0;
                    for (int i = 0; i < span_used[s]; i++) begin
                        len = span_hi[s][i] - span_lo[s][i];
                        if (sum > TIME_MAX - len) sum = TIME_MAX;
                        else sum = sum + len;
                    end
                    item.stage = STAGE_W'(s);
                    item.total = sum;
                    item.ovf   = dropped;
                    item.last  = (s == NUM_STAGES - 1);
                    sums_due = {sums_due, item};
                end
                for (int s = 0; s < NUM_STAGES; s++) span_used[s] = 0;
                dropped = 1'b0;
            end
        endfunction

        task check_result(input logic [STAGE_W-1:0] stage, input logic [TIME_W-1:0] total,
                          input logic ovf, input logic last, input logic [OUT_PAD_W-1:0] pad);
            t_stage_sum want;
            results++;
            if (sums_due.size() == 0) begin
                log_mismatch($sformatf("unexpected result for stage %0d", stage));
                return;
            end
            want = sums_due.pop_front();
            if (stage !== want.stage)
                log_mismatch($sformatf("stage %0d, expected %0d", stage, want.stage));
            if (total !== want.total)
                log_mismatch($sformatf("stage %0d total %0h, expected %0h",
                                       want.stage, total, want.total));
            if (ovf !== want.ovf)
                log_mismatch($sformatf("stage %0d overflow %b, expected %b",
                                       want.stage, ovf, want.ovf));
            if (last !== want.last)
                log_mismatch($sformatf("stage %0d tlast %b, expected %b",
                                       want.stage, last, want.last));
            if (pad !== '0)
                log_mismatch($sformatf("stage %0d tdata pad %0h, expected zero",
                                       want.stage, pad));
        endtask
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;   // start_time, end_time
    logic [IN_TUSER_W-1:0]  i_s_axis_tuser;   // command, stage
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;   // total_time, overflow, zero pad
    logic [OUT_TUSER_W-1:0] o_m_axis_tuser;   // out_stage
    logic                   o_m_axis_tlast;

    span_scoreboard sb = new();
    bit             gaps_on = 1'b1;
    bit             quiet = 1'b0;
    bit             hold_request = 1'b0;
    int unsigned    cycle_count = 0;

    interval_union_length_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("interval_union_length_unit regression: fail");
            $finish;
        end
    end

    function automatic logic [TIME_W-1:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Offers one item and returns right after the edge that accepts it.
    task send_item(input t_command cmd, input logic [STAGE_W-1:0] stage,
                   input logic [TIME_W-1:0] lo, input logic [TIME_W-1:0] hi);
        bit taken;
        if (!quiet && gaps_on && $urandom_range(0, 4) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {hi, lo};
        i_s_axis_tuser  <= {stage, cmd};
        do begin
            @(negedge i_clk);
            taken = o_s_axis_tready;
            @(posedge i_clk);
        end while (!taken);
        sb.note_input(cmd, stage, lo, hi);
    endtask

    // Result side: random stall bursts, plus one long hold-off on request.
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        i_m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES;
            end else if (stall_left == 0 && !quiet && gaps_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 15);
            end
            if (stall_left != 0) begin
                i_m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // Result monitor: the handshake is sampled mid-cycle, checked at the edge.
    initial begin
        logic [OUT_TDATA_W-1:0] data;
        logic [OUT_TUSER_W-1:0] user;
        logic                   lastv;
        bit                     got;
        forever begin
            @(negedge i_clk);
            got   = i_rst_n && o_m_axis_tvalid && i_m_axis_tready;
            data  = o_m_axis_tdata;
            user  = o_m_axis_tuser;
            lastv = o_m_axis_tlast;
            @(posedge i_clk);
            if (got) begin
                sb.check_result(user, data[TIME_W-1:0], data[TIME_W], lastv,
                                data[OUT_TDATA_W-1 -: OUT_PAD_W]);
            end
        end
    end

    initial begin
        logic [TIME_W-1:0] base, lo, hi, step;
        logic [STAGE_W-1:0] st;
        int unsigned       n, mode, w, counted;
        counted = 0;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Touching at either end, then one interval bridging two disjoint entries.
        send_item(CMD_ADD, 2'd0, 64'd100, 64'd200);
        send_item(CMD_ADD, 2'd0, 64'd200, 64'd300);
        send_item(CMD_ADD, 2'd0, 64'd50, 64'd100);
        send_item(CMD_ADD, 2'd0, 64'd400, 64'd500);
        send_item(CMD_ADD, 2'd0, 64'd600, 64'd700);
        send_item(CMD_ADD, 2'd0, 64'd450, 64'd650);
        send_item(CMD_ADD, 2'd1, 64'd0, TIME_MAX);
        send_item(CMD_ADD, 2'd2, 64'd5000, 64'd5000);
        // Both of these are ignored: end before start, and an unknown stage.
        send_item(CMD_ADD, 2'd1, TIME_MAX, TIME_MAX - 1);
        send_item(CMD_ADD, 2'd3, 64'd10, TIME_MAX);
        // Fill stage 2, overflow it, then merge into the full table.
        for (int k = 0; k < MAX_INTERVALS - 1; k++) begin
            send_item(CMD_ADD, 2'd2, 64'(k * 10), 64'(k * 10 + 5));
        end
        send_item(CMD_ADD, 2'd2, 64'd2000, 64'd2001);
        send_item(CMD_ADD, 2'd2, 64'd3, 64'd12);
        send_item(CMD_REPORT, 2'($urandom_range(0, 3)), rand64(), rand64());
        send_item(CMD_REPORT, 2'($urandom_range(0, 3)), rand64(), rand64());

        // The result side stalls for a long stretch while traffic continues.
        hold_request = 1'b1;
        while (counted < RANDOM_ITEMS) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            quiet   = (counted + QUIET_ITEMS > RANDOM_ITEMS);
            mode    = $urandom_range(0, 9);
            w       = $urandom_range(64, 4096);
            case ($urandom_range(0, 3))
                0: base = '0;
                1: base = TIME_MAX - SPAN_ROOM;
                default: begin
                    base = rand64();
                    if (base > TIME_MAX - SPAN_ROOM) base = TIME_MAX - SPAN_ROOM;
                end
            endcase
            if (mode < 7) begin
                // Clustered intervals in a narrow window, so merges are frequent.
                n = $urandom_range(1, 24);
                for (int k = 0; k < n; k++) begin
                    st = 2'($urandom_range(0, 2));
                    if ($urandom_range(0, 15) == 0) begin
                        lo = rand64();
                        hi = rand64();
                        if (hi < lo) begin
                            step = lo;
                            lo   = hi;
                            hi   = step;
                        end
                    end else begin
                        lo = base + $urandom_range(0, w);
                        hi = lo + $urandom_range(0, w / 6);
                    end
                    send_item(CMD_ADD, st, lo, hi);
                    counted++;
                    if ($urandom_range(0, 11) == 0) begin
                        lo = rand64();
                        if ($urandom_range(0, 1) == 0) begin
                            send_item(CMD_ADD, 2'd3, lo, rand64());
                        end else begin
                            if (lo == '0) lo = 64'd1;
                            send_item(CMD_ADD, 2'($urandom_range(0, 2)), lo, rand64() % lo);
                        end
                    end
                end
            end else begin
                // Spaced, non-touching intervals in one stage to reach a full table.
                st   = 2'($urandom_range(0, 2));
                n    = $urandom_range(MAX_INTERVALS - 4, MAX_INTERVALS + 4);
                step = $urandom_range(4, 200);
                for (int k = 0; k < n; k++) begin
                    lo = base + k * step;
                    hi = lo + $urandom_range(0, step - 2);
                    send_item(CMD_ADD, st, lo, hi);
                    counted++;
                end
            end
            send_item(CMD_REPORT, 2'($urandom_range(0, 3)), rand64(), rand64());
            counted++;
        end
        i_s_axis_tvalid <= 1'b0;

        while (sb.sums_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.sums_due.size() != 0) begin
            sb.log_mismatch($sformatf("%0d sums never arrived", sb.sums_due.size()));
        end

        $display("Covered %0d adds (%0d merging, %0d dropped on a full table), %0d ignored items",
                 sb.adds, sb.absorbs, sb.drops, sb.ignored);
        $display("and %0d reports; %0d stage sums checked in %0d cycles.",
                 sb.reports, sb.results, cycle_count);
        if (sb.mismatches == 0) begin
            $display("interval_union_length_unit regression: pass");
        end else begin
            $display("interval_union_length_unit regression: fail");
        end
        $finish;
    end

endmodule
